// ===== rtl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared sizes, field widths and types of the direct-mapped cache lookup.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int SET_COUNT     = 16384;
  localparam int BACKING_BYTES = 65536;
  localparam int QUEUE_DEPTH   = 2;

  localparam int ADDR_W  = 32;
  localparam int LOWER_W = 16;
  localparam int TAG_W   = ADDR_W - LOWER_W;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 32;
  localparam int OFFS_W  = 2;
  localparam int LINE_BYTES = 4;
  localparam int LINE_W  = LINE_BYTES * BYTE_W;
  localparam int SET_W   = $clog2(SET_COUNT);
  localparam int BK_W    = $clog2(BACKING_BYTES);
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam int S_DATA_W = ((ADDR_W + BYTE_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((BYTE_W + 2 * CNT_W + 7) / 8) * 8;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ACCESS = 1'b1;

  typedef struct packed {
    logic              is_access;
    logic [TAG_W-1:0]  tag;
    logic [SET_W-1:0]  set;
    logic [OFFS_W-1:0] offs;
    logic [BK_W-1:0]   bidx;
    logic [BYTE_W-1:0] load_byte;
  } cmd_t;

  typedef struct packed {
    logic cleared;
  } back_status_t;

endpackage

// ===== rtl/dmc_ram.sv =====
// ----------------------------------------------------------------------------
// dmc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dmc_queue.sv =====
// ----------------------------------------------------------------------------
// dmc_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dmc_queue import dmc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/dmc_front.sv =====
// ----------------------------------------------------------------------------
// dmc_front
// Accept transactions, split the address into tag, set, offset and backing
// index, and hand the decoded command to the queue.
// ----------------------------------------------------------------------------
module dmc_front import dmc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [0:0]          s_tuser,
  input  back_status_t        status,
  input  logic                q_full,
  output logic                q_push,
  output cmd_t                q_data
);

  logic [ADDR_W-1:0] addr;
  cmd_t              dec;
  cmd_t              held_cmd;
  logic              held;
  logic              held_next;
  logic              accept;

  assign addr = s_tdata[ADDR_W-1:0];

  always_comb begin
    dec.is_access = (s_tuser[0] == ACT_ACCESS);
    dec.tag       = addr[ADDR_W-1:LOWER_W];
    dec.set       = addr[SET_W+OFFS_W-1:OFFS_W];
    dec.offs      = addr[OFFS_W-1:0];
    dec.bidx      = addr[BK_W-1:0];
    dec.load_byte = s_tdata[ADDR_W +: BYTE_W];
  end

  assign q_push   = held && !q_full;
  assign q_data   = held_cmd;
  assign s_tready = status.cleared && (!held || !q_full);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = 1'b1;
    end else if (q_push) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_cmd <= dec;
    end
  end

endmodule

// ===== rtl/dmc_back.sv =====
// ----------------------------------------------------------------------------
// dmc_back
// Carry out queued commands: backing loads, tag lookup, line refill,
// saturating counters and the result register.
// ----------------------------------------------------------------------------
module dmc_back import dmc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  cmd_t                q_head,
  output logic                q_pop,
  output back_status_t        status,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [0:0]          m_tuser
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_TAG   = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;

  logic [SET_W-1:0] clr_idx;
  cmd_t             cur;
  logic [OFFS_W-1:0] fill_idx;
  logic [LINE_BYTES-1:0][BYTE_W-1:0] line_buf;
  logic [LINE_BYTES-1:0][BYTE_W-1:0] line_fill;
  logic              res_hit;
  logic [BYTE_W-1:0] res_byte;
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  miss_cnt;

  logic              tag_we;
  logic [SET_W-1:0]  tag_waddr;
  logic [TAG_W:0]    tag_wdata;
  logic [TAG_W:0]    tag_rdata;
  logic [LINE_W-1:0] line_rdata;
  logic              line_we;
  logic              bk_we;
  logic [BK_W-1:0]   bk_raddr;
  logic [BYTE_W-1:0] bk_rdata;
  logic              lookup_hit;
  logic              out_free;

  assign out_free   = !m_tvalid || m_tready;
  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign lookup_hit = tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == cur.tag);

  assign status.cleared = (state != ST_CLEAR);

  always_comb begin
    line_fill           = line_buf;
    line_fill[fill_idx] = bk_rdata;
  end

  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = cur.set;
    tag_wdata = {1'b1, cur.tag};
    line_we   = 1'b0;
    if (state == ST_CLEAR) begin
      tag_we    = 1'b1;
      tag_waddr = clr_idx;
      tag_wdata = '0;
    end else if ((state == ST_FILL) && (fill_idx == OFFS_W'(LINE_BYTES - 1))) begin
      tag_we  = 1'b1;
      line_we = 1'b1;
    end
  end

  assign bk_we    = q_pop && !q_head.is_access;
  assign bk_raddr = (state == ST_TAG) ? {cur.bidx[BK_W-1:OFFS_W], OFFS_W'(0)}
                                      : {cur.bidx[BK_W-1:OFFS_W], fill_idx + 1'b1};

  dmc_ram #(.DEPTH(SET_COUNT), .WIDTH(TAG_W + 1)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (q_head.set),
    .rdata (tag_rdata)
  );

  dmc_ram #(.DEPTH(SET_COUNT), .WIDTH(LINE_W)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (cur.set),
    .wdata (line_fill),
    .raddr (q_head.set),
    .rdata (line_rdata)
  );

  dmc_ram #(.DEPTH(BACKING_BYTES), .WIDTH(BYTE_W)) u_backing_ram (
    .clk   (clk),
    .we    (bk_we),
    .waddr (q_head.bidx),
    .wdata (q_head.load_byte),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_W'(SET_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          state_next = q_head.is_access ? ST_TAG : ST_DONE;
        end
      end
      ST_TAG: begin
        state_next = lookup_hit ? ST_DONE : ST_FILL;
      end
      ST_FILL: begin
        if (fill_idx == OFFS_W'(LINE_BYTES - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      hit_cnt  <= '0;
      miss_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if ((state == ST_TAG) && lookup_hit && (hit_cnt != '1)) begin
        hit_cnt <= hit_cnt + 1'b1;
      end
      if (line_we && (miss_cnt != '1)) begin
        miss_cnt <= miss_cnt + 1'b1;
      end
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_head;
      res_hit  <= 1'b0;
      res_byte <= '0;
    end
    if (state == ST_TAG) begin
      fill_idx <= '0;
      if (lookup_hit) begin
        res_hit  <= 1'b1;
        res_byte <= line_rdata[{cur.offs, 3'b000} +: BYTE_W];
      end
    end
    if (state == ST_FILL) begin
      line_buf[fill_idx] <= bk_rdata;
      fill_idx           <= fill_idx + 1'b1;
      if (fill_idx == OFFS_W'(LINE_BYTES - 1)) begin
        res_byte <= line_fill[cur.offs];
      end
    end
    if ((state == ST_DONE) && out_free) begin
      m_tuser <= res_hit;
      m_tdata <= M_DATA_W'({miss_cnt, hit_cnt, res_byte});
    end
  end

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !q_pop)
    else $error("command taken during clearing pass");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result offered outside completion");
  a_one_counter: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !((hit_cnt != $past(hit_cnt)) && (miss_cnt != $past(miss_cnt))))
    else $error("hit and miss counted together");
  a_hit_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (hit_cnt >= $past(hit_cnt)))
    else $error("hit counter went backwards");

endmodule

// ===== rtl/direct_mapped_cache_lookup_top.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_cache_lookup_top
// Direct-mapped read cache in front of a byte-wide backing memory.
// ----------------------------------------------------------------------------
// After reset the tag store is swept clear, one set per cycle, over all SET_COUNT
// (16384) sets; s_tready stays low until the sweep ends. A load transaction
// (tuser 0) writes one backing byte; an access transaction (tuser 1) looks up
// the 16-bit tag in the set chosen by address bits 15..2 and returns one
// result per input. Inputs pass a holding register and a two-entry queue, so
// new transactions are taken while the back end works or a result waits. The
// back end runs a load from idle to done, a hit through tag to done, and a
// miss through tag and fill, refilling the line by four one-byte backing reads.
module direct_mapped_cache_lookup_top import dmc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // address[31:0], load_byte[39:32]
  input  logic [0:0]          s_tuser,   // action[0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // read_byte[7:0], hits_so_far[39:8],
                                         // misses_so_far[71:40]
  output logic [0:0]          m_tuser    // hit[0]
);

  back_status_t status;
  logic         q_push;
  cmd_t         q_data;
  logic         q_full;
  logic         q_pop;
  cmd_t         q_head;
  logic         q_empty;

  dmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .status   (status),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  dmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  dmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
